// ----- hdl/mkdc_pkg.sv -----
package mkdc_pkg;

  localparam int unsigned NumKeysDef    = 4;
  localparam int unsigned CountWidthDef = 32;

  localparam int unsigned DebW   = 16;
  localparam int unsigned TicksW = 32;
  localparam int unsigned RegIdxW = 2;
  localparam int unsigned AddrW   = RegIdxW + 2;
  localparam int unsigned DataW   = 32;

  localparam logic [DebW-1:0]   DebounceReset  = 16'd10;
  localparam logic [TicksW-1:0] LongPressReset = 32'd1000;
  localparam logic [TicksW-1:0] ComboReset     = 32'd10000;

  typedef enum logic [RegIdxW-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_COMBO_HOLD = 2'd2,
    REG_ACTIVE_LOW = 2'd3
  } mkdc_reg_e;

  // per key outcome of one tick
  typedef struct packed {
    logic press_ev;
    logic release_ev;
    logic long_ev;
    logic pressed;
    logic led;
  } mkdc_lane_st_t;

endpackage

// ----- hdl/mkdc_if.sv -----
interface mkdc_key_if import mkdc_pkg::*; #(
  parameter int unsigned NumKeys = NumKeysDef
);
  logic               valid;
  logic               ready;
  logic [NumKeys-1:0] key_levels;

  modport source (output valid, output key_levels, input ready);
  modport sink   (input valid, input key_levels, output ready);
endinterface

interface mkdc_res_if import mkdc_pkg::*; #(
  parameter int unsigned NumKeys = NumKeysDef
);
  logic               valid;
  logic               ready;
  logic [NumKeys-1:0] press_events;
  logic [NumKeys-1:0] release_events;
  logic [NumKeys-1:0] long_press;
  logic [NumKeys-1:0] key_pressed;
  logic [NumKeys-1:0] led_state;
  logic               erase_request;

  modport source (
    output valid, output press_events, output release_events, output long_press,
    output key_pressed, output led_state, output erase_request, input ready
  );
  modport sink (
    input valid, input press_events, input release_events, input long_press,
    input key_pressed, input led_state, input erase_request, output ready
  );
endinterface

// ----- hdl/mkdc_key_lane.sv -----
module mkdc_key_lane import mkdc_pkg::*; #(
  parameter int unsigned CountWidth = CountWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              level_i,
  input  logic              active_low_i,
  input  logic [DebW-1:0]   dlen_i,
  input  logic [TicksW-1:0] long_ticks_i,
  output mkdc_lane_st_t     st_o
);

  localparam int unsigned CmpW = (CountWidth > TicksW) ? CountWidth : TicksW;

  logic                  prev_q, prev_d;
  logic                  pressed_q, pressed_d;
  logic                  run_q, run_d;
  logic                  led_q, led_d;
  logic [DebW-1:0]       remain_q, remain_d;
  logic [CountWidth-1:0] hold_q, hold_d;

  logic                  at_press, expire, run_mid, start;
  logic                  press_ev, rel_ev, long_ev;
  logic [CountWidth-1:0] hold_inc;

  always_comb begin
    at_press = level_i ^ active_low_i;
    hold_inc = (pressed_q && (hold_q != '1)) ? hold_q + CountWidth'(1) : hold_q;
    // a running countdown never sits at zero, so expiry is the step from one
    expire   = run_q && (remain_q <= DebW'(1));
    press_ev = expire && !pressed_q && at_press;
    rel_ev   = expire && pressed_q && !at_press;
    long_ev  = rel_ev && (CmpW'(hold_inc) > CmpW'(long_ticks_i));
    pressed_d = pressed_q ^ (press_ev | rel_ev);
    run_mid   = run_q && !expire;
    start     = (level_i != prev_q) && !run_mid && (at_press != pressed_d);
    run_d     = run_mid || start;
    if (start) begin
      remain_d = dlen_i;
    end else if (run_q && (remain_q != '0)) begin
      remain_d = remain_q - DebW'(1);
    end else begin
      remain_d = remain_q;
    end
    hold_d = press_ev ? '0 : hold_inc;
    led_d  = led_q ^ rel_ev;
    prev_d = level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= 1'b1;
      pressed_q <= 1'b0;
      run_q     <= 1'b0;
      led_q     <= 1'b0;
      remain_q  <= '0;
      hold_q    <= '0;
    end else if (step_i) begin
      prev_q    <= prev_d;
      pressed_q <= pressed_d;
      run_q     <= run_d;
      led_q     <= led_d;
      remain_q  <= remain_d;
      hold_q    <= hold_d;
    end
  end

  assign st_o.press_ev   = press_ev;
  assign st_o.release_ev = rel_ev;
  assign st_o.long_ev    = long_ev;
  assign st_o.pressed    = pressed_d;
  assign st_o.led        = led_d;

endmodule

// ----- hdl/mkdc_combo.sv -----
module mkdc_combo import mkdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              all_pressed_i,
  input  logic              any_press_i,
  input  logic [TicksW-1:0] combo_len_i,
  output logic              erase_o
);

  logic              run_q, run_d;
  logic [TicksW-1:0] remain_q, remain_d;
  logic              expire, restart;

  always_comb begin
    expire  = run_q && (remain_q <= TicksW'(1));
    restart = any_press_i && all_pressed_i;
    erase_o = expire && all_pressed_i;
    run_d   = restart || (run_q && !expire);
    if (restart) begin
      remain_d = combo_len_i;
    end else if (run_q && (remain_q != '0)) begin
      remain_d = remain_q - TicksW'(1);
    end else begin
      remain_d = remain_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      remain_q <= '0;
    end else if (step_i) begin
      run_q    <= run_d;
      remain_q <= remain_d;
    end
  end

endmodule

// ----- hdl/multi_key_debounce_press_classifier.sv -----
// Debounce and press classifier for a row of keys, one sample tick per transfer.
// in_i carries key_levels, the raw level of each key, once per tick. out_o
// returns one result per tick: debounce press/release events, long press flags
// for released keys, the debounced pressed state, the LED toggle bits and a
// one-tick erase request when all keys stay held for the combo time.
// A tick enters an input register on its transfer and moves on to the output
// register in the next cycle unless the receiver stalls; a new tick is taken
// every cycle while results move on. The per-key counters and the combo counter
// update in one pass of short logic between those two registers.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more tick; after that in_i.ready drops until
// the result moves on.
// Reset clears all key state (keys released, LEDs off, no countdowns) and loads
// the register defaults: debounce 10, long press 1000, combo 10000 ticks,
// all keys active low. Registers sit on the APB port at 4*index; the user must
// make writes only while no tick is in flight, the block does not enforce it.
module multi_key_debounce_press_classifier import mkdc_pkg::*; #(
  parameter int unsigned NumKeys    = NumKeysDef,
  parameter int unsigned CountWidth = CountWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mkdc_key_if.sink          in_i,
  mkdc_res_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  logic [DebW-1:0]    deb_q;
  logic [TicksW-1:0]  long_q;
  logic [TicksW-1:0]  combo_q;
  logic [NumKeys-1:0] mask_q;
  mkdc_reg_e          reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = mkdc_reg_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q   <= DebounceReset;
      long_q  <= LongPressReset;
      combo_q <= ComboReset;
      mask_q  <= '1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEBOUNCE:   deb_q   <= pwdata[DebW-1:0];
        REG_LONG_PRESS: long_q  <= pwdata[TicksW-1:0];
        REG_COMBO_HOLD: combo_q <= pwdata[TicksW-1:0];
        REG_ACTIVE_LOW: mask_q  <= pwdata[NumKeys-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE:   prdata = DataW'(deb_q);
      REG_LONG_PRESS: prdata = DataW'(long_q);
      REG_COMBO_HOLD: prdata = DataW'(combo_q);
      REG_ACTIVE_LOW: prdata = DataW'(mask_q);
      default:        prdata = '0;
    endcase
  end

  // zero lengths count as one tick
  logic [DebW-1:0]   dlen;
  logic [TicksW-1:0] clen;
  assign dlen = (deb_q == '0) ? DebW'(1) : deb_q;
  assign clen = (combo_q == '0) ? TicksW'(1) : combo_q;

  // input register and result register handshake
  logic               s1_valid_q;
  logic [NumKeys-1:0] s1_levels_q;
  logic               out_valid_q;
  logic               step;

  assign step        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_levels_q <= in_i.key_levels;
    end
  end

  mkdc_lane_st_t      lane_st [NumKeys];
  logic [NumKeys-1:0] press_v, release_v, long_v, pressed_v, led_v;
  logic               erase;

  for (genvar k = 0; k < NumKeys; k++) begin : g_lane
    mkdc_key_lane #(
      .CountWidth(CountWidth)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (step),
      .level_i     (s1_levels_q[k]),
      .active_low_i(mask_q[k]),
      .dlen_i      (dlen),
      .long_ticks_i(long_q),
      .st_o        (lane_st[k])
    );
  end

  always_comb begin
    for (int k = 0; k < NumKeys; k++) begin
      press_v[k]   = lane_st[k].press_ev;
      release_v[k] = lane_st[k].release_ev;
      long_v[k]    = lane_st[k].long_ev;
      pressed_v[k] = lane_st[k].pressed;
      led_v[k]     = lane_st[k].led;
    end
  end

  mkdc_combo u_combo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .all_pressed_i(&pressed_v),
    .any_press_i  (|press_v),
    .combo_len_i  (clen),
    .erase_o      (erase)
  );

  logic [NumKeys-1:0] press_q, release_q, long_q_r, pressed_q, led_q;
  logic               erase_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      press_q   <= press_v;
      release_q <= release_v;
      long_q_r  <= long_v;
      pressed_q <= pressed_v;
      led_q     <= led_v;
      erase_q   <= erase;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.press_events   = press_q;
  assign out_o.release_events = release_q;
  assign out_o.long_press     = long_q_r;
  assign out_o.key_pressed    = pressed_q;
  assign out_o.led_state      = led_q;
  assign out_o.erase_request  = erase_q;

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("tick advanced without a result");

  a_erase_all_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && erase_q |-> (pressed_q == '1))
    else $error("erase request while not all keys pressed");

  a_long_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((long_q_r & ~release_q) == '0))
    else $error("long press flag without release");

  a_events_match_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (((press_q & ~pressed_q) == '0) && ((release_q & pressed_q) == '0)))
    else $error("event disagrees with pressed state");

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import mkdc_pkg::*;

  localparam int unsigned NK = NumKeysDef;
  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned TIMEOUT_CYCLES = 400000;

  typedef struct packed {
    logic [NK-1:0] press_ev;
    logic [NK-1:0] rel_ev;
    logic [NK-1:0] long_ev;
    logic [NK-1:0] pressed;
    logic [NK-1:0] led;
    logic          erase;
  } tick_res_t;

  typedef struct {
    logic [NK-1:0] levels;
    int unsigned   gap;
  } tick_item_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  mkdc_key_if #(.NumKeys(NK)) key_if ();
  mkdc_res_if #(.NumKeys(NK)) res_if ();

  multi_key_debounce_press_classifier #(
    .NumKeys   (NK),
    .CountWidth(CountWidthDef)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (key_if),
    .out_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // predictor copy of the registers
  logic [DebW-1:0]          cfg_debounce   = DebounceReset;
  logic [TicksW-1:0]        cfg_long       = LongPressReset;
  logic [TicksW-1:0]        cfg_combo      = ComboReset;
  logic [NK-1:0]            cfg_active_low = '1;

  // predictor copy of the key state
  logic [NK-1:0]            lvl_prev  = '1;
  logic [NK-1:0]            pressed_q = '0;
  logic [NK-1:0]            deb_run   = '0;
  logic [NK-1:0]            led_q     = '0;
  logic [DebW-1:0]          deb_left [NK];
  logic [CountWidthDef-1:0] held     [NK];
  logic                     combo_on   = 1'b0;
  logic [TicksW-1:0]        combo_left = '0;

  tick_res_t   outcome_q [$];
  tick_item_t  level_q [$];
  tick_item_t  cur_tick;
  bit          key_busy, key_taken, res_taken;
  int unsigned gap_left, sink_stall, res_count, mismatch_count;
  logic [NK-1:0] gen_mask;

  initial begin
    for (int k = 0; k < NK; k++) begin
      deb_left[k] = '0;
      held[k]     = '0;
    end
  end

  function automatic tick_res_t classify_tick(input logic [NK-1:0] levels);
    logic [NK-1:0]   at_press;
    logic [NK-1:0]   changed;
    logic [DebW-1:0] dlen;
    tick_res_t       r;
    int              k;
    r        = '0;
    at_press = levels ^ cfg_active_low;
    changed  = levels ^ lvl_prev;
    dlen     = (cfg_debounce == '0) ? DebW'(1) : cfg_debounce;
    for (k = 0; k < NK; k++) begin
      if (pressed_q[k] && held[k] != '1) held[k] = held[k] + 1'b1;
    end
    for (k = 0; k < NK; k++) begin
      if (deb_run[k]) begin
        if (deb_left[k] != '0) deb_left[k] = deb_left[k] - 1'b1;
        if (deb_left[k] == '0) begin
          deb_run[k] = 1'b0;
          if (!pressed_q[k]) begin
            if (at_press[k]) begin
              pressed_q[k]  = 1'b1;
              held[k]       = '0;
              r.press_ev[k] = 1'b1;
            end
          end else if (!at_press[k]) begin
            pressed_q[k] = 1'b0;
            r.rel_ev[k]  = 1'b1;
            if (held[k] > cfg_long) r.long_ev[k] = 1'b1;
            led_q[k] = ~led_q[k];
          end
        end
      end
    end
    // a new countdown only where the level moved away from the debounced state
    for (k = 0; k < NK; k++) begin
      if (changed[k] && !deb_run[k] && (at_press[k] != pressed_q[k])) begin
        deb_run[k]  = 1'b1;
        deb_left[k] = dlen;
      end
    end
    lvl_prev = levels;
    if (combo_on) begin
      if (combo_left != '0) combo_left = combo_left - 1'b1;
      if (combo_left == '0) begin
        combo_on = 1'b0;
        if (&pressed_q) r.erase = 1'b1;
      end
    end
    if (r.press_ev != '0 && &pressed_q) begin
      combo_on   = 1'b1;
      combo_left = (cfg_combo == '0) ? TicksW'(1) : cfg_combo;
    end
    r.pressed = pressed_q;
    r.led     = led_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string fname, input logic [NK-1:0] got,
                             input logic [NK-1:0] want, input int unsigned idx);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h expected %h", idx, fname, got, want));
  endtask

  // key channel driver
  always @(negedge clk_i) begin : key_driver
    if (key_taken) begin
      key_busy  = 1'b0;
      key_taken = 1'b0;
    end
    if (!key_busy && level_q.size() > 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        cur_tick = level_q.pop_front();
        key_busy = 1'b1;
        gap_left = (level_q.size() > 0) ? level_q[0].gap : 0;
      end
    end
    key_if.valid      <= key_busy;
    key_if.key_levels <= cur_tick.levels;
  end

  // result channel stalls, with calm stretches
  always @(negedge clk_i) begin : res_sink
    if (res_taken) begin
      res_taken  = 1'b0;
      sink_stall = ((res_count / 64) % 3 == 1) ? 0 : $urandom_range(0, 5);
    end
    if (sink_stall > 0) begin
      sink_stall--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : monitor
    tick_res_t got, want;
    if (rst_ni) begin
      if (key_if.valid && key_if.ready) begin
        outcome_q.push_back(classify_tick(key_if.key_levels));
        key_taken = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        res_taken = 1'b1;
        got.press_ev = res_if.press_events;
        got.rel_ev   = res_if.release_events;
        got.long_ev  = res_if.long_press;
        got.pressed  = res_if.key_pressed;
        got.led      = res_if.led_state;
        got.erase    = res_if.erase_request;
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no tick outstanding", res_count));
        end else begin
          want = outcome_q.pop_front();
          check_field("press_events", got.press_ev, want.press_ev, res_count);
          check_field("release_events", got.rel_ev, want.rel_ev, res_count);
          check_field("long_press", got.long_ev, want.long_ev, res_count);
          check_field("key_pressed", got.pressed, want.pressed, res_count);
          check_field("led_state", got.led, want.led, res_count);
          check_field("erase_request", NK'(got.erase), NK'(want.erase), res_count);
        end
        res_count++;
      end
    end
  end

  task automatic wait_drained();
    while (level_q.size() != 0 || key_busy || outcome_q.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input mkdc_reg_e idx, input logic [DataW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_DEBOUNCE:   cfg_debounce   = data[DebW-1:0];
      REG_LONG_PRESS: cfg_long       = data[TicksW-1:0];
      REG_COMBO_HOLD: cfg_combo      = data[TicksW-1:0];
      REG_ACTIVE_LOW: cfg_active_low = data[NK-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(input logic [DebW-1:0] deb, input logic [TicksW-1:0] lng,
                            input logic [TicksW-1:0] cmb, input logic [NK-1:0] msk);
    logic [DataW-1:0] junk;
    wait_drained();
    junk = $urandom;
    // unused upper bits carry noise
    reg_write(REG_DEBOUNCE, {junk[DataW-1:DebW], deb});
    reg_write(REG_LONG_PRESS, lng);
    reg_write(REG_COMBO_HOLD, cmb);
    junk = $urandom;
    reg_write(REG_ACTIVE_LOW, {junk[DataW-1:NK], msk});
    gen_mask = msk;
  endtask

  task automatic push_tick(input logic [NK-1:0] levels, input int unsigned gap);
    tick_item_t it;
    it.levels = levels;
    it.gap    = gap;
    level_q.push_back(it);
  endtask

  initial begin : stimulus
    int unsigned    p, n, k, items, gdeb, gspan, combo_gen;
    int unsigned    bounce [NK];
    logic [NK-1:0]  tgt, lv;
    logic [DebW-1:0]   deb;
    logic [TicksW-1:0] lng, cmb;
    logic [NK-1:0]     msk;

    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    key_if.valid      = 1'b0;
    key_if.key_levels = '1;
    res_if.ready      = 1'b0;
    cur_tick.levels   = '1;
    cur_tick.gap      = 0;
    gen_mask          = '1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults: bounce during the countdown, then all keys pressed
    push_tick(4'hF, 0);
    push_tick(4'h0, 1);
    push_tick(4'hF, 0);
    for (n = 0; n < 9; n++) push_tick(4'h0, n % 3);

    // zero debounce and zero combo lengths act as one tick
    set_config('0, '0, '0, 4'hF);
    push_tick(4'h0, 0);
    push_tick(4'hF, 0);
    push_tick(4'h0, 2);   // expiry with level back at pressed: no event
    push_tick(4'hF, 0);
    push_tick(4'hF, 0);   // release of all keys, long since held > 0
    push_tick(4'h0, 0);
    push_tick(4'h0, 1);   // press of all keys restarts combo
    push_tick(4'h0, 0);   // combo expires: erase pulse
    push_tick(4'h5, 0);
    push_tick(4'h5, 3);

    tgt = '0;
    for (k = 0; k < NK; k++) bounce[k] = 0;
    combo_gen = 0;
    for (p = 0; p < 9; p++) begin
      items = 200;
      case (p)
        0: begin deb = 16'd1; lng = 32'd2; cmb = 32'd3; msk = 4'h0; end
        1: begin deb = 16'd3; lng = 32'd0; cmb = 32'd1; msk = 4'hF; end
        // longest countdowns last, they never expire within the run
        8: begin
          deb = 16'hFFFF; lng = 32'hFFFF_FFFF; cmb = 32'hFFFF_FFFF; msk = 4'h5;
          items = 60;
        end
        3: begin deb = 16'd2; lng = 32'hFFFF_FFFF; cmb = 32'd8; msk = 4'hA; end
        default: begin
          deb = DebW'($urandom_range(1, 6));
          lng = $urandom_range(0, 25);
          cmb = $urandom_range(1, 40);
          msk = NK'($urandom_range(0, 15));
        end
      endcase
      set_config(deb, lng, cmb, msk);
      gdeb  = (deb > 20) ? 20 : deb;
      gspan = 3 * gdeb + 6;
      for (n = 0; n < items; n++) begin
        // now and then hold every key down long enough for the combo
        if (combo_gen == 0 && $urandom_range(0, 79) == 0) begin
          combo_gen = ((cmb > 60) ? 60 : cmb) + gdeb + $urandom_range(2, 10);
          tgt = '1;
        end
        if (combo_gen > 0) combo_gen--;
        for (k = 0; k < NK; k++) begin
          if (combo_gen == 0 && $urandom_range(0, gspan) == 0) begin
            tgt[k]    = ~tgt[k];
            bounce[k] = $urandom_range(0, 3);
          end
          if (bounce[k] > 0) begin
            lv[k] = 1'($urandom_range(0, 1));
            bounce[k]--;
          end else begin
            lv[k] = tgt[k] ? ~gen_mask[k] : gen_mask[k];
          end
        end
        if ($urandom_range(0, 9) == 0) lv = NK'($urandom_range(0, 15));
        push_tick(lv, ((n / 40) % 3 == 0) ? 0 : $urandom_range(0, 5));
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("multi_key_debounce_press_classifier: match");
    end else begin
      $display("multi_key_debounce_press_classifier: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("multi_key_debounce_press_classifier: mismatch");
    $finish;
  end

endmodule
